### hdl/ccr_pkg.sv
// Shared types, widths and codes for the closed Catmull-Rom path stepper.
package ccr_pkg;

  localparam int PT_W            = 32;
  localparam int STEP_W          = 16;
  localparam int COEF_W          = 36;
  localparam int MIN_POINTS      = 3;
  localparam int DEF_MAX_POINTS  = 256;
  localparam int DEF_T_FRAC_BITS = 16;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic signed [PT_W-1:0] z;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    point_t            pt;
  } entry_t;

  typedef struct packed {
    logic coef_en;
    logic mult_en;
    logic sum_en;
  } eval_ctrl_t;

endpackage

### hdl/closed_catmull_rom_path_stepper.sv
// Top level of the closed uniform Catmull-Rom path stepper: sequencer and state.
// Usage: present an item on command, x_value, y_value, z_value and segment_step
// and raise start; the transfer happens at a rising edge where start is high
// and busy is low.
// A load (command 0) appends a point and its segment step in that edge and
// gives no result; loads beyond the memory depth are dropped. A load can be
// followed by another item in the next cycle.
// An advance with fewer than three points answers with done in the cycle after
// the transfer, zero coordinates and status 1, and keeps busy low.
// An advance with three or more points raises busy while it makes four reads
// through the single registered read port of the point memory; then the
// shared cubic datapath steps through coefficients, multiply, sum and store
// for x, y and z in turn. done is high once the z result is stored, and busy
// is already low there, so the next advance can be taken in that cycle.
// Each result is held on px, py, pz, lap_done and status for exactly the
// one cycle in which done is high; the receiver cannot stall it.
// Reset clears the point count, segment index, t and the lap flag; memory
// contents are not cleared, since only loaded entries are read.
module closed_catmull_rom_path_stepper #(
  parameter int MAX_POINTS  = ccr_pkg::DEF_MAX_POINTS,
  parameter int T_FRAC_BITS = ccr_pkg::DEF_T_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic signed [ccr_pkg::PT_W-1:0]   x_value,
  input  logic signed [ccr_pkg::PT_W-1:0]   y_value,
  input  logic signed [ccr_pkg::PT_W-1:0]   z_value,
  input  logic [ccr_pkg::STEP_W-1:0]        segment_step,
  output logic                              done,
  output logic signed [ccr_pkg::PT_W-1:0]   px,
  output logic signed [ccr_pkg::PT_W-1:0]   py,
  output logic signed [ccr_pkg::PT_W-1:0]   pz,
  output logic                              lap_done,
  output logic                              status
);
  import ccr_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IW    = AW + 2;
  localparam int TW    = T_FRAC_BITS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD1   = 4'd1;
  localparam logic [3:0] ST_RD2   = 4'd2;
  localparam logic [3:0] ST_RD3   = 4'd3;
  localparam logic [3:0] ST_CAP   = 4'd4;
  localparam logic [3:0] ST_COEF  = 4'd5;
  localparam logic [3:0] ST_MULT  = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_STORE = 4'd8;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  logic [3:0]       state;
  logic [1:0]       axis;
  logic [CNT_W-1:0] point_count;
  logic [AW-1:0]    segment_index;
  logic [TW-1:0]    curve_t;
  logic             wrapped_flag;

  logic [AW-1:0] j_r, ip1_r, ip2_r;
  logic          last_seg;
  logic [TW-1:0] t1_r, t2_r, t3_r;
  logic [STEP_W-1:0] step_j, step_ip1;
  point_t pp0, pp1, pp2, pp3;

  logic          accept;
  logic [IW-1:0] n_w, seg_w, j_w, im1_w, ip1_w, ip2_w, ip1_c, ip2_c;
  logic          count_full, not_ready;
  logic [AW-1:0] raddr;
  entry_t        wdata, rdata;
  logic          we;

  logic [2*TW-1:0]    tsq, tcube;
  logic [TW+STEP_W-1:0] sj_ext, sn_ext;
  logic [TW-1:0]      sf_j, sf_next;
  logic [TW:0]        t_sum;

  eval_ctrl_t ctrl;
  logic signed [PT_W-1:0] a0, a1, a2, a3, axis_result;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Segment index arithmetic, modulo the current point count.
  assign n_w     = IW'(point_count);
  assign seg_w   = IW'(segment_index);
  assign j_w     = (seg_w < n_w) ? seg_w : '0;
  assign im1_w   = (j_w == '0) ? n_w - IW'(1) : j_w - IW'(1);
  assign ip1_w   = j_w + IW'(1);
  assign ip2_w   = j_w + IW'(2);
  assign ip1_c   = (ip1_w >= n_w) ? ip1_w - n_w : ip1_w;
  assign ip2_c   = (ip2_w >= n_w) ? ip2_w - n_w : ip2_w;

  assign count_full = !(n_w < IW'(MAX_POINTS));
  assign not_ready  = n_w < IW'(MIN_POINTS);

  assign we            = accept && (command == CMD_LOAD) && !count_full;
  assign wdata.step    = segment_step;
  assign wdata.pt.x    = x_value;
  assign wdata.pt.y    = y_value;
  assign wdata.pt.z    = z_value;

  always_comb begin
    case (state)
      ST_IDLE: raddr = im1_w[AW-1:0];
      ST_RD1:  raddr = j_r;
      ST_RD2:  raddr = ip1_r;
      ST_RD3:  raddr = ip2_r;
      default: raddr = j_r;
    endcase
  end

  ccr_point_mem #(
    .DEPTH(MAX_POINTS),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(point_count[AW-1:0]),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Powers of t, truncated to the fraction width.
  assign tsq   = {{TW{1'b0}}, t1_r} * {{TW{1'b0}}, t1_r};
  assign tcube = {{TW{1'b0}}, t2_r} * {{TW{1'b0}}, t1_r};

  // A stored step is a Q0.16 value rescaled to the fraction width of t.
  assign sj_ext  = {step_j, {TW{1'b0}}};
  assign sn_ext  = {step_ip1, {TW{1'b0}}};
  assign sf_j    = sj_ext[TW+STEP_W-1:STEP_W];
  assign sf_next = sn_ext[TW+STEP_W-1:STEP_W];
  assign t_sum   = {1'b0, t1_r} + {1'b0, sf_j};

  assign ctrl.coef_en = (state == ST_COEF);
  assign ctrl.mult_en = (state == ST_MULT);
  assign ctrl.sum_en  = (state == ST_SUM);

  always_comb begin
    case (axis)
      AXIS_X: begin
        a0 = pp0.x; a1 = pp1.x; a2 = pp2.x; a3 = pp3.x;
      end
      AXIS_Y: begin
        a0 = pp0.y; a1 = pp1.y; a2 = pp2.y; a3 = pp3.y;
      end
      default: begin
        a0 = pp0.z; a1 = pp1.z; a2 = pp2.z; a3 = pp3.z;
      end
    endcase
  end

  ccr_axis_eval #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_eval (
    .clk   (clk),
    .ctrl  (ctrl),
    .p0    (a0),
    .p1    (a1),
    .p2    (a2),
    .p3    (a3),
    .t1    (t1_r),
    .t2    (t2_r),
    .t3    (t3_r),
    .result(axis_result)
  );

  // Sequencer and walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      axis          <= AXIS_X;
      point_count   <= '0;
      segment_index <= '0;
      curve_t       <= '0;
      wrapped_flag  <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (command == CMD_LOAD) begin
              if (!count_full) begin
                point_count <= point_count + CNT_W'(1);
              end
            end else if (not_ready) begin
              done <= 1'b1;
            end else begin
              state <= ST_RD1;
            end
          end
        end
        ST_RD1:  state <= ST_RD2;
        ST_RD2:  state <= ST_RD3;
        ST_RD3:  state <= ST_CAP;
        ST_CAP: begin
          // When t passes one, the next segment is the entry read as j+1; else j stays.
          if (t_sum[TW]) begin
            segment_index <= ip1_r;
            curve_t       <= sf_next;
            wrapped_flag  <= wrapped_flag | last_seg;
          end else begin
            segment_index <= j_r;
            curve_t       <= t_sum[TW-1:0];
          end
          axis  <= AXIS_X;
          state <= ST_COEF;
        end
        ST_COEF: state <= ST_MULT;
        ST_MULT: state <= ST_SUM;
        ST_SUM:  state <= ST_STORE;
        ST_STORE: begin
          if (axis == AXIS_Z) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_COEF;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_ADVANCE) begin
          j_r      <= j_w[AW-1:0];
          ip1_r    <= ip1_c[AW-1:0];
          ip2_r    <= ip2_c[AW-1:0];
          last_seg <= (ip1_w >= n_w);
          t1_r     <= curve_t;
          if (not_ready) begin
            px       <= '0;
            py       <= '0;
            pz       <= '0;
            lap_done <= wrapped_flag;
            status   <= STATUS_NOT_READY;
          end
        end
      end
      ST_RD1: begin
        pp0  <= rdata.pt;
        t2_r <= tsq[2*TW-1:TW];
      end
      ST_RD2: begin
        pp1    <= rdata.pt;
        step_j <= rdata.step;
        t3_r   <= tcube[2*TW-1:TW];
      end
      ST_RD3: begin
        pp2      <= rdata.pt;
        step_ip1 <= rdata.step;
      end
      ST_CAP: begin
        pp3      <= rdata.pt;
        lap_done <= wrapped_flag | (t_sum[TW] & last_seg);
        status   <= STATUS_OK;
      end
      ST_STORE: begin
        case (axis)
          AXIS_X:  px <= axis_result;
          AXIS_Y:  py <= axis_result;
          default: pz <= axis_result;
        endcase
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_walk_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_ADVANCE && !not_ready) |-> ##17 done)
    else $error("advance result not delivered after the fixed latency");

  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_ADVANCE && not_ready) |=>
      (done && status == STATUS_NOT_READY && !busy))
    else $error("short-path advance did not answer with not-ready status");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is still working");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (point_count == '0) || (IW'(segment_index) < n_w))
    else $error("segment index outside the loaded points");
`endif

endmodule

### hdl/ccr_point_mem.sv
// Control point and segment step memory: one write port, one registered read port.
module ccr_point_mem #(
  parameter int DEPTH = ccr_pkg::DEF_MAX_POINTS,
  parameter int AW    = $clog2(ccr_pkg::DEF_MAX_POINTS)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ccr_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output ccr_pkg::entry_t rdata
);
  import ccr_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/ccr_axis_eval.sv
// Per-axis cubic datapath: coefficients, three multiplies, sum, rounding and saturation.
module ccr_axis_eval #(
  parameter int T_FRAC_BITS = ccr_pkg::DEF_T_FRAC_BITS
) (
  input  logic                            clk,
  input  ccr_pkg::eval_ctrl_t             ctrl,
  input  logic signed [ccr_pkg::PT_W-1:0] p0,
  input  logic signed [ccr_pkg::PT_W-1:0] p1,
  input  logic signed [ccr_pkg::PT_W-1:0] p2,
  input  logic signed [ccr_pkg::PT_W-1:0] p3,
  input  logic [T_FRAC_BITS-1:0]          t1,
  input  logic [T_FRAC_BITS-1:0]          t2,
  input  logic [T_FRAC_BITS-1:0]          t3,
  output logic signed [ccr_pkg::PT_W-1:0] result
);
  import ccr_pkg::*;

  localparam int PROD_W = COEF_W + T_FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [SUM_W-1:0] HALF = {{(SUM_W-1){1'b0}}, 1'b1} << T_FRAC_BITS;

  logic signed [COEF_W-1:0] e0, e1, e2, e3;
  logic signed [COEF_W-1:0] ca, cb, cc, cd;
  logic signed [T_FRAC_BITS:0] tx1, tx2, tx3;
  logic signed [PROD_W-1:0] mb, mc, md;
  logic signed [SUM_W-1:0] sum, sum_a, rnd, q;
  logic [SUM_W-PT_W:0] hi;

  assign e0 = {{(COEF_W-PT_W){p0[PT_W-1]}}, p0};
  assign e1 = {{(COEF_W-PT_W){p1[PT_W-1]}}, p1};
  assign e2 = {{(COEF_W-PT_W){p2[PT_W-1]}}, p2};
  assign e3 = {{(COEF_W-PT_W){p3[PT_W-1]}}, p3};

  assign tx1 = $signed({1'b0, t1});
  assign tx2 = $signed({1'b0, t2});
  assign tx3 = $signed({1'b0, t3});

  always_ff @(posedge clk) begin
    if (ctrl.coef_en) begin
      ca <= e1 <<< 1;
      cb <= e2 - e0;
      cc <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      cd <= ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mult_en) begin
      mb <= PROD_W'(cb) * PROD_W'(tx1);
      mc <= PROD_W'(cc) * PROD_W'(tx2);
      md <= PROD_W'(cd) * PROD_W'(tx3);
    end
  end

  assign sum_a = {{(SUM_W-COEF_W){ca[COEF_W-1]}}, ca} <<< T_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum <= sum_a
           + {{2{mb[PROD_W-1]}}, mb}
           + {{2{mc[PROD_W-1]}}, mc}
           + {{2{md[PROD_W-1]}}, md};
    end
  end

  // Halving with round half up is a floor of (sum + half) over two units of t.
  assign rnd = sum + $signed(HALF);
  assign q   = rnd >>> (T_FRAC_BITS + 1);
  assign hi  = q[SUM_W-1:PT_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      result = q[PT_W-1:0];
    end else if (q[SUM_W-1]) begin
      result = {1'b1, {(PT_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(PT_W-1){1'b1}}};
    end
  end

endmodule

### dv/tb.sv
// Testbench for the closed Catmull-Rom path stepper: stimulus, path prediction and result checks.
`timescale 1ns / 100ps

module tb;
  import ccr_pkg::*;

  localparam int MAX_PTS        = DEF_MAX_POINTS;
  localparam int T_FRAC         = DEF_T_FRAC_BITS;
  localparam int T_ONE          = 1 << T_FRAC;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 24;
  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -64'sd2147483648;

  typedef struct {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic signed [PT_W-1:0] pz;
    logic                   lap;
    logic                   status;
  } path_sample_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   command;
  logic signed [PT_W-1:0] x_value;
  logic signed [PT_W-1:0] y_value;
  logic signed [PT_W-1:0] z_value;
  logic [STEP_W-1:0]      segment_step;
  logic                   done;
  logic signed [PT_W-1:0] px;
  logic signed [PT_W-1:0] py;
  logic signed [PT_W-1:0] pz;
  logic                   lap_done;
  logic                   status;

  // Local copy of the path state.
  int                path_x [MAX_PTS];
  int                path_y [MAX_PTS];
  int                path_z [MAX_PTS];
  logic [STEP_W-1:0] path_step [MAX_PTS];
  int                n_points;
  int                seg_idx;
  int                t_cur;
  logic              lap_flag;

  path_sample_t expected_samples[$];
  int           error_count;
  int           gap_pct;
  int           idle_cycles;

  closed_catmull_rom_path_stepper dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .x_value      (x_value),
    .y_value      (y_value),
    .z_value      (z_value),
    .segment_step (segment_step),
    .done         (done),
    .px           (px),
    .py           (py),
    .pz           (pz),
    .lap_done     (lap_done),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Half of the cubic, rounded to nearest with ties upward, then saturated.
  function automatic logic signed [PT_W-1:0] cubic_axis(input longint p0, p1, p2, p3,
                                                        input longint t1, t2, t3);
    longint a, b, c, d, acc, r;
    a = 2 * p1;
    b = p2 - p0;
    c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    d = 3 * p1 - 3 * p2 + p3 - p0;
    acc = (a <<< T_FRAC) + b * t1 + c * t2 + d * t3;
    r = (acc + (64'sd1 <<< T_FRAC)) >>> (T_FRAC + 1);
    if (r > SAT_HI) r = SAT_HI;
    else if (r < SAT_LO) r = SAT_LO;
    return r[PT_W-1:0];
  endfunction

  task automatic step_path_model(input logic cmd, input int xv, yv, zv,
                                 input logic [STEP_W-1:0] sv);
    path_sample_t s;
    int j, jm1, jp1, jp2;
    longint t1, t2, t3;
    if (cmd == CMD_LOAD) begin
      if (n_points < MAX_PTS) begin
        path_x[n_points] = xv;
        path_y[n_points] = yv;
        path_z[n_points] = zv;
        path_step[n_points] = sv;
        n_points++;
      end
    end else if (n_points < MIN_POINTS) begin
      s.px = '0;
      s.py = '0;
      s.pz = '0;
      s.lap = lap_flag;
      s.status = STATUS_NOT_READY;
      expected_samples.insert(expected_samples.size(), s);
    end else begin
      j = (seg_idx >= n_points) ? 0 : seg_idx;
      jm1 = (j == 0) ? n_points - 1 : j - 1;
      jp1 = (j + 1) % n_points;
      jp2 = (j + 2) % n_points;
      t1 = t_cur % T_ONE;
      t2 = (t1 * t1) >>> T_FRAC;
      t3 = (t2 * t1) >>> T_FRAC;
      s.px = cubic_axis(path_x[jm1], path_x[j], path_x[jp1], path_x[jp2], t1, t2, t3);
      s.py = cubic_axis(path_y[jm1], path_y[j], path_y[jp1], path_y[jp2], t1, t2, t3);
      s.pz = cubic_axis(path_z[jm1], path_z[j], path_z[jp1], path_z[jp2], t1, t2, t3);
      t_cur = int'(t1) + int'(path_step[j]);
      if (t_cur >= T_ONE) begin
        j++;
        if (j >= n_points) begin
          lap_flag = 1'b1;
          j = 0;
        end
        t_cur = int'(path_step[j]);
      end
      seg_idx = j;
      s.lap = lap_flag;
      s.status = STATUS_OK;
      expected_samples.insert(expected_samples.size(), s);
    end
  endtask

  // Start stays high from one transfer to the next unless an idle burst comes between.
  task automatic send_item(input logic cmd, input int xv, yv, zv,
                           input logic [STEP_W-1:0] sv);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    x_value      <= xv;
    y_value      <= yv;
    z_value      <= zv;
    segment_step <= sv;
    @(posedge clk);
    while (busy) @(posedge clk);
    step_path_model(cmd, xv, yv, zv, sv);
  endtask

  // Half full-range values, half small ones that keep the cubic out of saturation.
  function automatic int pick_coord();
    if ($urandom_range(0, 1) == 1) return $urandom;
    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
  endfunction

  task automatic send_advance();
    send_item(CMD_ADVANCE, $urandom, $urandom, $urandom,
              STEP_W'($urandom_range(0, 65535)));
  endtask

  task automatic check_field(input string name, input logic [PT_W-1:0] want, got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    path_sample_t want;
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual px %h py %h pz %h",
                 $time, px, py, pz);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        check_field("px", want.px, px);
        check_field("py", want.py, py);
        check_field("pz", want.pz, pz);
        check_field("lap_done", PT_W'(want.lap), PT_W'(lap_done));
        check_field("status", PT_W'(want.status), PT_W'(status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Advances with fewer than three points, each count from zero to two.
  task automatic test_not_ready();
    send_advance();
    send_item(CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF);
    send_advance();
    send_item(CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, -1, 16'h8000);
    send_advance();
  endtask

  // Extreme coordinates drive saturation; a few laps set the sticky flag.
  task automatic test_first_laps();
    send_item(CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 16'd40000);
    repeat (9) send_advance();
  endtask

  // Points loaded mid-walk join the loop and change the index wrap.
  task automatic test_late_loads();
    send_item(CMD_LOAD, 32'h0001_8000, -32'sh0002_4000, 32'h0000_0001, 16'hC000);
    send_advance();
    send_item(CMD_LOAD, -32'sh0000_8000, 32'h0003_0000, 32'h8000_0001, 16'h6000);
    repeat (3) send_advance();
  endtask

  task automatic test_random_walk();
    for (int i = 0; i < 1400; i++) begin
      if (i % 100 == 0) gap_pct = ((i / 100) % 2 == 0) ? 35 : 0;
      if (n_points < MAX_PTS - 2 && $urandom_range(0, 99) < 20)
        send_item(CMD_LOAD, pick_coord(), pick_coord(), pick_coord(),
                  STEP_W'($urandom_range(4096, 65535)));
      else
        send_advance();
    end
  endtask

  // Fill the store, try loads beyond it, then walk onto the zero-step segment.
  task automatic test_full_store_and_stall();
    gap_pct = 0;
    while (n_points < MAX_PTS - 2)
      send_item(CMD_LOAD, pick_coord(), pick_coord(), pick_coord(),
                STEP_W'($urandom_range(4096, 65535)));
    send_item(CMD_LOAD, pick_coord(), pick_coord(), pick_coord(), 16'd0);
    send_item(CMD_LOAD, pick_coord(), pick_coord(), pick_coord(), 16'd1);
    repeat (3) send_item(CMD_LOAD, $urandom, $urandom, $urandom,
                         STEP_W'($urandom_range(1, 65535)));
    while (seg_idx != MAX_PTS - 2) send_advance();
    repeat (8) send_advance();
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    command      <= CMD_LOAD;
    x_value      <= '0;
    y_value      <= '0;
    z_value      <= '0;
    segment_step <= '0;
    n_points     = 0;
    seg_idx      = 0;
    t_cur        = 0;
    lap_flag     = 1'b0;
    error_count  = 0;
    gap_pct      = 25;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_not_ready();
    test_first_laps();
    test_late_loads();
    test_random_walk();
    test_full_store_and_stall();

    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
